### rtl/gdu_pkg.sv
// Shared types, constants and calendar helper functions for the Gregorian date unit.
package gdu_pkg;

    // Operation selectors carried in tuser.
    localparam logic [1:0] KIND_NEXT  = 2'd0;
    localparam logic [1:0] KIND_PREV  = 2'd1;
    localparam logic [1:0] KIND_DIFF  = 2'd2;
    localparam logic [1:0] KIND_VALID = 2'd3;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int YOUT_W = 16;
    localparam int ORD_W = 22;
    localparam int DIFF_W = 23;
    localparam int Q25_W = 10;

    // y / 25 == (y * 5243) >> 17 for every 14-bit y.
    localparam logic [12:0] DIV25_MUL = 13'd5243;
    localparam int DIV25_SHIFT = 17;
    localparam int PROD_W = YEAR_W + 13;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
    localparam logic [DAY_W-1:0] LAST_DAY_DEC = 5'd31;
    localparam logic [ORD_W-1:0] DAYS_PER_YEAR = 22'd365;

    localparam int TDATA_IN_W = 48;
    localparam int TDATA_OUT_W = 56;

    typedef struct packed {
        logic [1:0]         kind;
        logic [YEAR_W-1:0]  year_a;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
        logic [YEAR_W-1:0]  year_b;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
    } req_t;

    typedef struct packed {
        req_t              req;
        logic [Q25_W-1:0]  q_ya;
        logic [Q25_W-1:0]  q_yb;
        logic [Q25_W-1:0]  q_pa;
        logic [Q25_W-1:0]  q_pb;
    } s1_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               valid_a;
        logic               valid_b;
        logic               leap_a;
        logic               leap_b;
        logic [MONTH_W-1:0] month_a;
        logic [DAY_W-1:0]   day_a;
        logic [MONTH_W-1:0] month_b;
        logic [DAY_W-1:0]   day_b;
        logic [ORD_W-1:0]   days_a;
        logic [ORD_W-1:0]   days_b;
        logic [YOUT_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
    } s2_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               valid_a;
        logic               valid_b;
        logic [ORD_W-1:0]   ord_a;
        logic [ORD_W-1:0]   ord_b;
        logic [YOUT_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
    } s3_t;

    // Leap when divisible by 4 and either not by 25 or also by 16.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [Q25_W-1:0] q);
        logic [YEAR_W-1:0] rem;
        rem = y - YEAR_W'(q) * 14'd25;
        return (y[1:0] == 2'd0) && ((rem != '0) || (y[3:0] == 4'd0));
    endfunction

    // Length of a month; zero for month codes outside January to December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd2:                                     len = leap ? 5'd29 : 5'd28;
            default:                                  len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m (common year).
    function automatic logic [8:0] month_before(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic date_ok(input logic [YEAR_W-1:0] y, input logic [DAY_W-1:0] d,
                                     input logic [DAY_W-1:0] len);
        return (y != '0) && (y <= YEAR_MAX) && (d != '0) && (d <= len);
    endfunction

endpackage

### rtl/gregorian_date_unit.sv
// Top level of the Gregorian date unit: input unpacking, three stages and the output register.
// An item passes the div, date and ord stage registers, then the output register, to m_tdata.
// Throughput: one item per cycle unless stalled; the four register stages each take one.
// A stalled output holds its item while empty stages upstream keep accepting new items.
// Reset clears only the stage valid bits; no state is kept between items.
module gregorian_date_unit
    import gdu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
    // day_b[45:41], zero fill [47:46]
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // year_out[15:0], month_out[19:16], day_out[24:20], day_difference[47:25],
    // valid_flag[48], zero fill [55:49]
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    req_t req;
    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;
    logic s3_valid;
    logic s3_ready;
    s3_t  s3_data;

    logic                   out_valid_reg;
    logic [TDATA_OUT_W-1:0] out_data_reg;
    logic [TDATA_OUT_W-1:0] out_data_next;
    logic                   both_valid;
    logic                   flag;
    logic [DIFF_W-1:0]      diff;

    always_comb
    begin
        req.kind    = s_tuser;
        req.year_a  = s_tdata[13:0];
        req.month_a = s_tdata[17:14];
        req.day_a   = s_tdata[22:18];
        req.year_b  = s_tdata[36:23];
        req.month_b = s_tdata[40:37];
        req.day_b   = s_tdata[45:41];
    end

    gdu_div_stage u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    gdu_date_stage u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    gdu_ord_stage u_ord (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    assign both_valid = s3_data.valid_a && s3_data.valid_b;
    assign flag = (s3_data.kind == KIND_DIFF) ? both_valid : s3_data.valid_a;
    assign diff = ((s3_data.kind == KIND_DIFF) && both_valid)
                  ? (DIFF_W'(s3_data.ord_b) - DIFF_W'(s3_data.ord_a)) : '0;
    assign out_data_next = {7'd0, flag, diff, s3_data.day_out, s3_data.month_out,
                            s3_data.year_out};

    assign s3_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s3_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // A nonzero day difference only comes with both dates valid.
    a_diff_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:25] == '0) || m_tdata[48])
        else $error("day difference reported for an invalid date pair");

    // An accepted item always lands in the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid)
        else $error("accepted item did not enter the first stage");

    // The last stage keeps its item while the output register is stalled.
    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid && !s3_ready |=> s3_valid && $stable(s3_data))
        else $error("last stage lost or changed its item under stall");

    // A stalled result stays in the output register.
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result dropped");

endmodule

### rtl/gdu_div_stage.sv
// First pipeline stage: divides the years and the years minus one by 25.
module gdu_div_stage
    import gdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output s1_t  out_data
);

    logic              valid_reg;
    s1_t               data_reg;
    s1_t               data_next;
    logic [YEAR_W-1:0] pa;
    logic [YEAR_W-1:0] pb;
    logic [PROD_W-1:0] prod_ya;
    logic [PROD_W-1:0] prod_yb;
    logic [PROD_W-1:0] prod_pa;
    logic [PROD_W-1:0] prod_pb;

    assign pa = in_data.year_a - 14'd1;
    assign pb = in_data.year_b - 14'd1;
    assign prod_ya = PROD_W'(in_data.year_a) * PROD_W'(DIV25_MUL);
    assign prod_yb = PROD_W'(in_data.year_b) * PROD_W'(DIV25_MUL);
    assign prod_pa = PROD_W'(pa) * PROD_W'(DIV25_MUL);
    assign prod_pb = PROD_W'(pb) * PROD_W'(DIV25_MUL);

    always_comb
    begin
        data_next.req  = in_data;
        data_next.q_ya = prod_ya[DIV25_SHIFT +: Q25_W];
        data_next.q_yb = prod_yb[DIV25_SHIFT +: Q25_W];
        data_next.q_pa = prod_pa[DIV25_SHIFT +: Q25_W];
        data_next.q_pb = prod_pb[DIV25_SHIFT +: Q25_W];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### rtl/gdu_date_stage.sv
// Second pipeline stage: leap years, validity, next and previous day, and days of whole years.
module gdu_date_stage
    import gdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic               valid_reg;
    s2_t                data_reg;
    s2_t                data_next;
    logic               leap_a;
    logic               leap_b;
    logic [DAY_W-1:0]   len_a;
    logic [DAY_W-1:0]   len_b;
    logic [YEAR_W-1:0]  pa;
    logic [YEAR_W-1:0]  pb;
    logic [DAY_W:0]     day_inc;
    logic [MONTH_W:0]   month_inc;
    logic [YOUT_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;

    assign leap_a = is_leap(in_data.req.year_a, in_data.q_ya);
    assign leap_b = is_leap(in_data.req.year_b, in_data.q_yb);
    assign len_a = month_len(in_data.req.month_a, leap_a);
    assign len_b = month_len(in_data.req.month_b, leap_b);
    assign pa = in_data.req.year_a - 14'd1;
    assign pb = in_data.req.year_b - 14'd1;
    assign day_inc = {1'b0, in_data.req.day_a} + 6'd1;
    assign month_inc = {1'b0, in_data.req.month_a} + 5'd1;

    always_comb
    begin
        year_out  = '0;
        month_out = '0;
        day_out   = '0;
        case (in_data.req.kind)
            KIND_NEXT:
            begin
                year_out  = YOUT_W'(in_data.req.year_a);
                month_out = in_data.req.month_a;
                day_out   = day_inc[DAY_W-1:0];
                if (day_inc > {1'b0, len_a})
                begin
                    day_out = 5'd1;
                    if (month_inc > {1'b0, LAST_MONTH})
                    begin
                        month_out = 4'd1;
                        year_out  = YOUT_W'(in_data.req.year_a) + 16'd1;
                    end
                    else
                    begin
                        month_out = month_inc[MONTH_W-1:0];
                    end
                end
            end
            KIND_PREV:
            begin
                year_out  = YOUT_W'(in_data.req.year_a);
                month_out = in_data.req.month_a;
                day_out   = in_data.req.day_a - 5'd1;
                if (in_data.req.day_a <= 5'd1)
                begin
                    if (in_data.req.month_a >= 4'd2)
                    begin
                        month_out = in_data.req.month_a - 4'd1;
                        day_out   = month_len(in_data.req.month_a - 4'd1, leap_a);
                    end
                    else
                    begin
                        year_out  = YOUT_W'(in_data.req.year_a) - 16'd1;
                        month_out = LAST_MONTH;
                        day_out   = LAST_DAY_DEC;
                    end
                end
            end
            default:
            begin
                year_out  = '0;
                month_out = '0;
                day_out   = '0;
            end
        endcase
    end

    always_comb
    begin
        data_next.kind      = in_data.req.kind;
        data_next.valid_a   = date_ok(in_data.req.year_a, in_data.req.day_a, len_a);
        data_next.valid_b   = date_ok(in_data.req.year_b, in_data.req.day_b, len_b);
        data_next.leap_a    = leap_a;
        data_next.leap_b    = leap_b;
        data_next.month_a   = in_data.req.month_a;
        data_next.day_a     = in_data.req.day_a;
        data_next.month_b   = in_data.req.month_b;
        data_next.day_b     = in_data.req.day_b;
        // Days before January 1 of the year: 365 per year plus leap days up to the prior year.
        data_next.days_a    = ORD_W'(pa) * DAYS_PER_YEAR + ORD_W'(pa >> 2)
                              - ORD_W'(in_data.q_pa >> 2) + ORD_W'(in_data.q_pa >> 4);
        data_next.days_b    = ORD_W'(pb) * DAYS_PER_YEAR + ORD_W'(pb >> 2)
                              - ORD_W'(in_data.q_pb >> 2) + ORD_W'(in_data.q_pb >> 4);
        data_next.year_out  = year_out;
        data_next.month_out = month_out;
        data_next.day_out   = day_out;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### rtl/gdu_ord_stage.sv
// Third pipeline stage: completes the day ordinal of both dates.
module gdu_ord_stage
    import gdu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;
    logic after_feb_a;
    logic after_feb_b;

    assign after_feb_a = (in_data.month_a > 4'd2) && in_data.leap_a;
    assign after_feb_b = (in_data.month_b > 4'd2) && in_data.leap_b;

    always_comb
    begin
        data_next.kind      = in_data.kind;
        data_next.valid_a   = in_data.valid_a;
        data_next.valid_b   = in_data.valid_b;
        data_next.ord_a     = in_data.days_a + ORD_W'(month_before(in_data.month_a))
                              + ORD_W'(after_feb_a) + ORD_W'(in_data.day_a) - 22'd1;
        data_next.ord_b     = in_data.days_b + ORD_W'(month_before(in_data.month_b))
                              + ORD_W'(after_feb_b) + ORD_W'(in_data.day_b) - 22'd1;
        data_next.year_out  = in_data.year_out;
        data_next.month_out = in_data.month_out;
        data_next.day_out   = in_data.day_out;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule
